// ===== rtl/core/mcmt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mcmt_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int QUEUE_DEPTH  = 8;
  localparam int WORD_BITS    = 32;

  localparam int ID_W   = 8;
  localparam int MSG_W  = 32;
  localparam int CHAN_W = 4;
  localparam int CH_W   = $clog2(NUM_CHANNELS);
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_CHANNELS * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(MEM_DEPTH);

  // request queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int QP_W    = $clog2(Q_DEPTH);
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_SEND  = 2'd1,
    OP_RECV  = 2'd2,
    OP_FREE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOFREE  = 3'd1,
    ST_BADID   = 3'd2,
    ST_NOTLIVE = 3'd3,
    ST_FULL    = 3'd4,
    ST_EMPTY   = 3'd5
  } status_t;

  typedef struct packed {
    op_t              op;
    logic             bad_id;
    logic [ID_W-1:0]  id;
    logic [MSG_W-1:0] word;
  } req_t;

endpackage
`default_nettype wire

// ===== rtl/core/multi_channel_mailbox_table_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// mailbox table: 16 channels, each with a live flag and an 8-word ring
// request channel: req_valid/req_stall with mode, chan_id and msg_word;
//   mode 0 allocates the lowest free channel, 1 sends msg_word, 2 receives
//   the oldest word, 3 frees the channel and drops its queued words
// response channel: rsp_valid/rsp_stall with ok, status, chan_out, msg_out;
//   exactly one response word per request word, in request order
// the back takes no new request word until it is done with the last: its
//   execute step updates the channel table and reads the message memory,
//   and a response state then loads the response register
// a front stage and a 2-entry queue take requests while the back waits
// on a stalled response; req_stall rises once the queue and front are full
// reset: all channels not live, pointers and fill levels zero; takes effect
//   at once, no clearing pass; message memory is not cleared
// a stalled response holds steady until taken
module multi_channel_mailbox_table_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  output logic                              req_stall,
  input  wire logic [1:0]                   mode,
  input  wire logic [mcmt_pkg::ID_W-1:0]    chan_id,
  input  wire logic [mcmt_pkg::MSG_W-1:0]   msg_word,
  output logic                              rsp_valid,
  input  wire logic                         rsp_stall,
  output logic                              ok,
  output logic [2:0]                        status,
  output logic [mcmt_pkg::CHAN_W-1:0]       chan_out,
  output logic [mcmt_pkg::MSG_W-1:0]        msg_out
);
  import mcmt_pkg::*;

  logic push;
  req_t push_req;
  logic q_full;
  logic pop;
  logic q_valid;
  req_t q_req;

  mcmt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .mode      (mode),
    .chan_id   (chan_id),
    .msg_word  (msg_word),
    .push      (push),
    .push_req  (push_req),
    .q_full    (q_full)
  );

  mcmt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_req    (q_req)
  );

  mcmt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .ok        (ok),
    .status    (status),
    .chan_out  (chan_out),
    .msg_out   (msg_out)
  );

endmodule
`default_nettype wire

// ===== rtl/core/mcmt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mcmt_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     req_valid,
  output logic                          req_stall,
  input  wire logic [1:0]               mode,
  input  wire logic [mcmt_pkg::ID_W-1:0]  chan_id,
  input  wire logic [mcmt_pkg::MSG_W-1:0] msg_word,
  output logic                          push,
  output mcmt_pkg::req_t                push_req,
  input  wire logic                     q_full
);
  import mcmt_pkg::*;

  logic stg_valid;
  req_t stg_req;
  req_t cls_req;
  logic accept;

  always_comb begin
    cls_req.op     = op_t'(mode);
    cls_req.bad_id = (chan_id >= ID_W'(NUM_CHANNELS));
    cls_req.id     = chan_id;
    cls_req.word   = msg_word;
  end

  assign push      = stg_valid && !q_full;
  assign req_stall = stg_valid && q_full;
  assign accept    = req_valid && !req_stall;
  assign push_req  = stg_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (accept) begin
      stg_valid <= 1'b1;
    end else if (push) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_req <= cls_req;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mcmt_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mcmt_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire mcmt_pkg::req_t push_req,
  output logic                full,
  input  wire logic           pop,
  output logic                q_valid,
  output mcmt_pkg::req_t      q_req
);
  import mcmt_pkg::*;

  req_t            slot [Q_DEPTH];
  logic [QP_W-1:0] wr_ptr;
  logic [QP_W-1:0] rd_ptr;
  logic [QC_W-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == QC_W'(Q_DEPTH));
  assign q_valid = (count != '0);
  assign q_req   = slot[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QP_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QP_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_req;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mcmt_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mcmt_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_valid,
  input  wire mcmt_pkg::req_t               q_req,
  output logic                              pop,
  output logic                              rsp_valid,
  input  wire logic                         rsp_stall,
  output logic                              ok,
  output logic [2:0]                        status,
  output logic [mcmt_pkg::CHAN_W-1:0]       chan_out,
  output logic [mcmt_pkg::MSG_W-1:0]        msg_out
);
  import mcmt_pkg::*;

  typedef enum logic {B_IDLE, B_RESP} bstate_t;

  bstate_t state;

  logic [NUM_CHANNELS-1:0] live;
  logic [PTR_W-1:0]        rd_ptr [NUM_CHANNELS];
  logic [PTR_W-1:0]        wr_ptr [NUM_CHANNELS];
  logic [FILL_W-1:0]       fill   [NUM_CHANNELS];

  logic [WORD_BITS-1:0] mem [MEM_DEPTH];
  logic [WORD_BITS-1:0] rd_data;

  logic                ex;
  logic [CH_W-1:0]     idx;
  logic [CH_W-1:0]     free_idx;
  logic                any_free;
  logic [CH_W+CHAN_W-1:0] free_ext;
  status_t             ex_status;
  logic [CHAN_W-1:0]   ex_chan;
  logic                send_ok;
  logic                recv_ok;
  logic [PTR_W-1:0]    ptr_sel;
  logic [ADDR_W-1:0]   addr;
  logic [WORD_BITS+MSG_W-1:0] wr_ext;
  logic [WORD_BITS+MSG_W-1:0] rd_ext;

  status_t           r_status;
  logic [CHAN_W-1:0] r_chan;
  logic              r_rd;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign ex  = (state == B_IDLE) && q_valid && (!rsp_valid || !rsp_stall);
  assign pop = ex;
  assign idx = q_req.id[CH_W-1:0];

  // lowest channel that is not live
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int c = NUM_CHANNELS - 1; c >= 0; c--) begin
      if (!live[c]) begin
        any_free = 1'b1;
        free_idx = CH_W'(c);
      end
    end
  end

  assign free_ext = {{CHAN_W{1'b0}}, free_idx};

  always_comb begin
    ex_status = ST_OK;
    ex_chan   = q_req.id[CHAN_W-1:0];
    send_ok   = 1'b0;
    recv_ok   = 1'b0;
    if (q_req.op == OP_ALLOC) begin
      if (any_free) begin
        ex_chan = free_ext[CHAN_W-1:0];
      end else begin
        ex_status = ST_NOFREE;
      end
    end else if (q_req.bad_id) begin
      ex_status = ST_BADID;
    end else if (!live[idx]) begin
      ex_status = ST_NOTLIVE;
    end else begin
      case (q_req.op)
        OP_SEND: begin
          if (fill[idx] == FILL_W'(QUEUE_DEPTH)) ex_status = ST_FULL;
          else send_ok = 1'b1;
        end
        OP_RECV: begin
          if (fill[idx] == '0) ex_status = ST_EMPTY;
          else recv_ok = 1'b1;
        end
        default: ex_status = ST_OK;
      endcase
    end
  end

  assign ptr_sel = send_ok ? wr_ptr[idx] : rd_ptr[idx];
  assign addr    = ADDR_W'(idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr_sel);
  assign wr_ext  = {{WORD_BITS{1'b0}}, q_req.word};
  assign rd_ext  = {{MSG_W{1'b0}}, rd_data};

  // channel table
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        rd_ptr[c] <= '0;
        wr_ptr[c] <= '0;
        fill[c]   <= '0;
      end
    end else if (ex) begin
      if (q_req.op == OP_ALLOC) begin
        if (any_free) begin
          live[free_idx]   <= 1'b1;
          rd_ptr[free_idx] <= '0;
          wr_ptr[free_idx] <= '0;
          fill[free_idx]   <= '0;
        end
      end else if (ex_status == ST_OK) begin
        case (q_req.op)
          OP_SEND: begin
            wr_ptr[idx] <= ring_next(wr_ptr[idx]);
            fill[idx]   <= fill[idx] + 1'b1;
          end
          OP_RECV: begin
            rd_ptr[idx] <= ring_next(rd_ptr[idx]);
            fill[idx]   <= fill[idx] - 1'b1;
          end
          default: begin
            live[idx]   <= 1'b0;
            rd_ptr[idx] <= '0;
            wr_ptr[idx] <= '0;
            fill[idx]   <= '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ex && send_ok) begin
      mem[addr] <= wr_ext[WORD_BITS-1:0];
    end
    if (ex) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (rsp_valid && !rsp_stall) begin
            rsp_valid <= 1'b0;
          end
          if (ex) begin
            r_status <= ex_status;
            r_chan   <= ex_chan;
            r_rd     <= recv_ok;
            state    <= B_RESP;
          end
        end
        B_RESP: begin
          rsp_valid <= 1'b1;
          ok        <= (r_status == ST_OK);
          status    <= r_status;
          chan_out  <= r_chan;
          msg_out   <= r_rd ? rd_ext[MSG_W-1:0] : '0;
          state     <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // output slot is always empty when a response gets written
  a_resp_slot_free: assert property (@(posedge clk) disable iff (rst)
    state == B_RESP |-> !rsp_valid)
    else $error("response written over a pending word");

  a_resp_follows: assert property (@(posedge clk) disable iff (rst)
    state == B_RESP |=> rsp_valid && state == B_IDLE)
    else $error("response not presented after execute");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    ex && q_req.op != OP_ALLOC && !q_req.bad_id |-> fill[idx] <= FILL_W'(QUEUE_DEPTH))
    else $error("fill level beyond ring depth");

  a_send_fill: assert property (@(posedge clk) disable iff (rst)
    ex && send_ok |=> fill[$past(idx)] == $past(fill[idx]) + 1'b1)
    else $error("send did not raise fill level");

  a_recv_fill: assert property (@(posedge clk) disable iff (rst)
    ex && recv_ok |=> fill[$past(idx)] == $past(fill[idx]) - 1'b1)
    else $error("receive did not lower fill level");

endmodule
`default_nettype wire

// ===== dv/multi_channel_mailbox_table_tb.sv =====
`timescale 1ns / 1ps
module testbench;
  import mcmt_pkg::*;

  localparam int RANDOM_ITEMS   = 450;
  localparam int CALM_FROM      = 380;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic              ok;
    status_t           st;
    logic [CHAN_W-1:0] chan;
    logic [MSG_W-1:0]  msg;
  } reply_t;

  class mbox_scoreboard;
    bit                 live [NUM_CHANNELS];
    int                 rd_slot [NUM_CHANNELS];
    int                 wr_slot [NUM_CHANNELS];
    int                 fill [NUM_CHANNELS];
    logic [MSG_W-1:0]   words [NUM_CHANNELS][QUEUE_DEPTH];
    reply_t             replies_due [$];
    int                 errors;

    function new();
      foreach (live[c]) begin
        live[c] = 1'b0;
        clear_ring(c);
      end
      errors = 0;
    endfunction

    function void clear_ring(int c);
      rd_slot[c] = 0;
      wr_slot[c] = 0;
      fill[c]    = 0;
    endfunction

    function int next_slot(int p);
      return (p == QUEUE_DEPTH - 1) ? 0 : p + 1;
    endfunction

    // runs the table forward by one accepted request word
    function void note_request(op_t op, logic [ID_W-1:0] id, logic [MSG_W-1:0] word);
      reply_t r;
      int ch;
      r.ok   = 1'b0;
      r.st   = ST_OK;
      r.chan = id[CHAN_W-1:0];
      r.msg  = '0;
      ch     = id;
      if (op == OP_ALLOC) begin
        r.st = ST_NOFREE;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (!live[c]) begin
            live[c] = 1'b1;
            clear_ring(c);
            r.chan = CHAN_W'(c);
            r.st   = ST_OK;
            break;
          end
        end
      end else if (ch >= NUM_CHANNELS) begin
        r.st = ST_BADID;
      end else if (!live[ch]) begin
        r.st = ST_NOTLIVE;
      end else if (op == OP_SEND) begin
        if (fill[ch] >= QUEUE_DEPTH) begin
          r.st = ST_FULL;
        end else begin
          words[ch][wr_slot[ch]] = word & {WORD_BITS{1'b1}};
          wr_slot[ch] = next_slot(wr_slot[ch]);
          fill[ch]++;
        end
      end else if (op == OP_RECV) begin
        if (fill[ch] == 0) begin
          r.st = ST_EMPTY;
        end else begin
          r.msg = words[ch][rd_slot[ch]];
          rd_slot[ch] = next_slot(rd_slot[ch]);
          fill[ch]--;
        end
      end else begin
        live[ch] = 1'b0;
        clear_ring(ch);
      end
      r.ok = (r.st == ST_OK);
      replies_due.push_back(r);
    endfunction

    function void check_response(logic ok_a, logic [2:0] st_a, logic [CHAN_W-1:0] chan_a,
                                 logic [MSG_W-1:0] msg_a);
      reply_t r;
      if (replies_due.size() == 0) begin
        $display("%0t: response with none due: ok %0b status %0d chan %0d msg %h",
                 $time, ok_a, st_a, chan_a, msg_a);
        errors++;
        return;
      end
      r = replies_due.pop_front();
      if (ok_a !== r.ok) begin
        $display("%0t: ok expected %0b actual %0b", $time, r.ok, ok_a);
        errors++;
      end
      if (st_a !== r.st) begin
        $display("%0t: status expected %0d actual %0d", $time, r.st, st_a);
        errors++;
      end
      if (chan_a !== r.chan) begin
        $display("%0t: chan_out expected %0d actual %0d", $time, r.chan, chan_a);
        errors++;
      end
      if (msg_a !== r.msg) begin
        $display("%0t: msg_out expected %h actual %h", $time, r.msg, msg_a);
        errors++;
      end
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  logic [1:0]        mode      = '0;
  logic [ID_W-1:0]   chan_id   = '0;
  logic [MSG_W-1:0]  msg_word  = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  logic              ok;
  logic [2:0]        status;
  logic [CHAN_W-1:0] chan_out;
  logic [MSG_W-1:0]  msg_out;

  mbox_scoreboard sb = new();
  bit calm = 1'b0;
  int hold_left = 0;
  int pass_left = 0;
  int idle_cycles = 0;

  always #10 clk = ~clk;

  multi_channel_mailbox_table_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .mode      (mode),
    .chan_id   (chan_id),
    .msg_word  (msg_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .ok        (ok),
    .status    (status),
    .chan_out  (chan_out),
    .msg_out   (msg_out)
  );

  // response side: take words, and stall in bursts between free-running stretches
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      sb.check_response(ok, status, chan_out, msg_out);
    end
    if (calm || rst) begin
      hold_left = 0;
      pass_left = 0;
      rsp_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (pass_left > 0) begin
      pass_left--;
      rsp_stall <= 1'b0;
    end else if ($urandom_range(0, 2) == 0) begin
      hold_left = $urandom_range(1, 15) - 1;
      rsp_stall <= 1'b1;
    end else begin
      pass_left = $urandom_range(1, 40);
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic issue(op_t op, logic [ID_W-1:0] id, logic [MSG_W-1:0] word);
    if (!calm && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    req_valid <= 1'b1;
    mode      <= op;
    chan_id   <= id;
    msg_word  <= word;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(op, id, word);
  endtask

  // mostly live channels so requests get past the id and live checks
  function automatic logic [ID_W-1:0] pick_id();
    int r;
    int n;
    int live_ids [$];
    r = $urandom_range(0, 99);
    for (n = 0; n < NUM_CHANNELS; n++) begin
      if (sb.live[n]) live_ids.push_back(n);
    end
    if (r < 8) return ID_W'($urandom_range(NUM_CHANNELS, 255));
    if (r < 20 || live_ids.size() == 0) return ID_W'($urandom_range(0, NUM_CHANNELS - 1));
    return ID_W'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
  endfunction

  function automatic logic [MSG_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  initial begin
    int r;
    op_t op;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    issue(OP_RECV, 8'd3, '0);
    issue(OP_SEND, 8'hff, 32'hffff_ffff);
    issue(OP_FREE, 8'd16, '0);
    issue(OP_ALLOC, 8'hff, 32'hdead_beef);
    issue(OP_SEND, 8'd0, 32'h0000_0000);
    issue(OP_SEND, 8'd0, 32'hffff_ffff);
    issue(OP_SEND, 8'd0, 32'h0000_0001);
    issue(OP_SEND, 8'd0, 32'h8000_0000);
    issue(OP_SEND, 8'd0, 32'h5a5a_5a5a);
    issue(OP_SEND, 8'd0, 32'ha5a5_a5a5);
    issue(OP_SEND, 8'd0, $urandom);
    issue(OP_SEND, 8'd0, $urandom);
    // ring is full now, word must be dropped
    issue(OP_SEND, 8'd0, 32'h1234_5678);
    repeat (QUEUE_DEPTH) issue(OP_RECV, 8'd0, $urandom);
    issue(OP_RECV, 8'd0, '0);
    issue(OP_FREE, 8'd0, '0);
    issue(OP_SEND, 8'd0, 32'hcafe_f00d);
    issue(OP_ALLOC, 8'd0, '0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (i < 150) begin
        // allocation heavy, fills the table until no channel is free
        op = (r < 35) ? OP_ALLOC : (r < 65) ? OP_SEND : (r < 90) ? OP_RECV : OP_FREE;
      end else if (i < 300) begin
        op = (r < 10) ? OP_ALLOC : (r < 50) ? OP_SEND : (r < 80) ? OP_RECV : OP_FREE;
      end else begin
        op = (r < 20) ? OP_ALLOC : (r < 55) ? OP_SEND : (r < 90) ? OP_RECV : OP_FREE;
      end
      if (i >= CALM_FROM) calm = 1'b1;
      issue(op, pick_id(), pick_word());
    end
    req_valid <= 1'b0;

    while (sb.replies_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
